>>> design/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// shared constants for the i2c master bit engine
// ----------------------------------------------------------------------------
package i2cm_pkg;

    localparam int BITS_PER_BYTE = 8;
    localparam int DATA_W        = 8;
    localparam int HALF_W        = 16;
    localparam int POLL_W        = 8;
    localparam int CMD_W         = 3;
    localparam int REG_IDX_W     = 1;

    localparam logic [CMD_W-1:0] CMD_START = 3'd0;
    localparam logic [CMD_W-1:0] CMD_STOP  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_WRITE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_READ  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_ACK   = 3'd4;

    localparam logic [REG_IDX_W-1:0] REG_HALF_PERIOD = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_ACK_POLLS   = 1'b1;

    localparam logic [HALF_W-1:0] HALF_PERIOD_RESET = 16'd80;
    localparam logic [POLL_W-1:0] ACK_POLLS_RESET   = 8'd20;

    typedef struct packed {
        logic              scl_level;
        logic              sda_drive;
        logic              sda_level;
        logic              last_phase;
        logic [DATA_W-1:0] read_byte;
        logic              acked;
        logic              timed_out;
    } t_phase;

endpackage

>>> design/i2cm_if.sv
// ----------------------------------------------------------------------------
// i2cm_if
// request, result and register write channels of the i2c master bit engine
// ----------------------------------------------------------------------------
interface i2cm_cmd_if;
    logic                           valid;
    logic                           ready;
    logic [i2cm_pkg::CMD_W-1:0]     cmd;
    logic [i2cm_pkg::DATA_W-1:0]    tx_byte;
    logic                           ack_level;
    logic [i2cm_pkg::DATA_W-1:0]    bus_read_bits;
    logic [i2cm_pkg::POLL_W-1:0]    slave_ack_delay;

    modport source (output valid, cmd, tx_byte, ack_level, bus_read_bits,
                    slave_ack_delay, input ready);
    modport sink   (input valid, cmd, tx_byte, ack_level, bus_read_bits,
                    slave_ack_delay, output ready);
endinterface

interface i2cm_res_if;
    logic                           valid;
    logic                           ready;
    logic                           scl_level;
    logic                           sda_drive;
    logic                           sda_level;
    logic                           last_phase;
    logic [i2cm_pkg::DATA_W-1:0]    read_byte;
    logic                           acked;
    logic                           timed_out;

    modport source (output valid, scl_level, sda_drive, sda_level, last_phase,
                    read_byte, acked, timed_out, input ready);
    modport sink   (input valid, scl_level, sda_drive, sda_level, last_phase,
                    read_byte, acked, timed_out, output ready);
endinterface

interface i2cm_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [i2cm_pkg::REG_IDX_W-1:0]   index;
    logic [i2cm_pkg::HALF_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> design/i2c_master_bit_engine.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_engine
// i2c master line engine: start, stop, write byte, read byte, send ack
// ----------------------------------------------------------------------------
// i_cmd takes one request (start, stop, write, read, ack); unknown codes are
// taken and dropped. o_res gives one result per bus line phase: scl level,
// sda drive enable and sda level, with last_phase on the final one and the
// read byte, ack and timeout status there. i_cfg writes the half period
// (index 0) and the ack poll limit (index 1); it is always ready, and the user
// must write it only while the engine is idle; the engine does not enforce it.
// Each phase waits on the shared phase timer, loaded with the half period,
// and then holds o_res until taken. Requests take 2 to 20 phases: start 3,
// stop 2, ack 2, read 16, write 19 (acked) or 20 (timed out, stop issued).
// i_cmd is not ready until the last phase of a request has been taken.
// A stalled receiver freezes the sequencer with the phase held on o_res.
// Reset returns to idle with the half period at 80 and the poll limit at 20.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    i2cm_cmd_if.sink    i_cmd,
    i2cm_res_if.source  o_res,
    i2cm_cfg_if.sink    i_cfg
);

    localparam int PH_W = $clog2(2 * i2cm_pkg::BITS_PER_BYTE + 4);
    localparam logic [PH_W-1:0] PH_BITS    = PH_W'(2 * i2cm_pkg::BITS_PER_BYTE);
    localparam logic [PH_W-1:0] PH_RD_LAST = PH_W'(2 * i2cm_pkg::BITS_PER_BYTE - 1);
    localparam logic [PH_W-1:0] PH_REL_LO  = PH_W'(2 * i2cm_pkg::BITS_PER_BYTE);
    localparam logic [PH_W-1:0] PH_REL_HI  = PH_W'(2 * i2cm_pkg::BITS_PER_BYTE + 1);
    localparam logic [PH_W-1:0] PH_ACK     = PH_W'(2 * i2cm_pkg::BITS_PER_BYTE + 2);
    localparam logic [PH_W-1:0] PH_ONE     = PH_W'(1);
    localparam logic [PH_W-1:0] PH_TWO     = PH_W'(2);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WAIT = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]                        r_state, n_state;
    logic [PH_W-1:0]                   r_ph, n_ph;
    logic [i2cm_pkg::HALF_W-1:0]       r_timer, n_timer;
    logic [i2cm_pkg::HALF_W-1:0]       r_half;
    logic [i2cm_pkg::POLL_W-1:0]       r_polls;
    logic [i2cm_pkg::CMD_W-1:0]        r_cmd;
    logic [i2cm_pkg::DATA_W-1:0]       r_shift, n_shift;
    logic                              r_ackl;
    logic                              r_tmo;
    i2cm_pkg::t_phase                  r_out, n_out;

    logic cmd_ok;
    logic in_acc;
    logic out_acc;
    logic bit_ph;
    logic tmo_now;

    assign i_cmd.ready = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign in_acc      = i_cmd.valid && i_cmd.ready;
    assign out_acc     = o_res.valid && o_res.ready;
    assign cmd_ok      = (i_cmd.cmd <= i2cm_pkg::CMD_ACK);
    assign bit_ph      = (r_ph < PH_BITS);
    assign tmo_now     = (r_polls != '0) && (i_cmd.slave_ack_delay >= r_polls);

    assign o_res.valid      = (r_state == ST_EMIT);
    assign o_res.scl_level  = r_out.scl_level;
    assign o_res.sda_drive  = r_out.sda_drive;
    assign o_res.sda_level  = r_out.sda_level;
    assign o_res.last_phase = r_out.last_phase;
    assign o_res.read_byte  = r_out.read_byte;
    assign o_res.acked      = r_out.acked;
    assign o_res.timed_out  = r_out.timed_out;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half  <= i2cm_pkg::HALF_PERIOD_RESET;
            r_polls <= i2cm_pkg::ACK_POLLS_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                i2cm_pkg::REG_HALF_PERIOD: r_half  <= i_cfg.data;
                i2cm_pkg::REG_ACK_POLLS:   r_polls <= i_cfg.data[i2cm_pkg::POLL_W-1:0];
                default: ;
            endcase
        end
    end

    // phase decode
    always_comb begin
        n_out = '0;
        case (r_cmd)
            i2cm_pkg::CMD_START: begin
                n_out.scl_level  = (r_ph != PH_TWO);
                n_out.sda_drive  = 1'b1;
                n_out.sda_level  = (r_ph == '0);
                n_out.last_phase = (r_ph == PH_TWO);
            end
            i2cm_pkg::CMD_STOP: begin
                n_out.scl_level  = 1'b1;
                n_out.sda_drive  = 1'b1;
                n_out.sda_level  = (r_ph == PH_ONE);
                n_out.last_phase = (r_ph == PH_ONE);
            end
            i2cm_pkg::CMD_ACK: begin
                n_out.scl_level  = (r_ph == '0);
                n_out.sda_drive  = 1'b1;
                n_out.sda_level  = r_ackl;
                n_out.last_phase = (r_ph == PH_ONE);
            end
            i2cm_pkg::CMD_WRITE: begin
                if (bit_ph) begin
                    n_out.scl_level = ~r_ph[0];
                    n_out.sda_drive = 1'b1;
                    n_out.sda_level = r_shift[i2cm_pkg::DATA_W-1];
                end else if (r_ph == PH_REL_LO) begin
                    n_out.scl_level = 1'b0;
                end else if (r_ph == PH_REL_HI) begin
                    n_out.scl_level = 1'b1;
                end else if (r_ph == PH_ACK) begin
                    n_out.sda_drive  = 1'b1;
                    n_out.scl_level  = r_tmo;
                    n_out.sda_level  = r_tmo ? 1'b0 : r_shift[0];
                    n_out.last_phase = ~r_tmo;
                    n_out.acked      = ~r_tmo;
                end else begin
                    n_out.scl_level  = 1'b1;
                    n_out.sda_drive  = 1'b1;
                    n_out.sda_level  = 1'b1;
                    n_out.last_phase = 1'b1;
                    n_out.timed_out  = 1'b1;
                end
            end
            default: begin
                n_out.scl_level  = ~r_ph[0];
                n_out.last_phase = (r_ph == PH_RD_LAST);
                n_out.read_byte  = (r_ph == PH_RD_LAST) ? r_shift : '0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_ph    = r_ph;
        n_timer = r_timer;
        n_shift = r_shift;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && cmd_ok) begin
                    n_state = ST_WAIT;
                    n_ph    = '0;
                    n_timer = r_half;
                    n_shift = (i_cmd.cmd == i2cm_pkg::CMD_READ) ? i_cmd.bus_read_bits
                                                                : i_cmd.tx_byte;
                end
            end
            ST_WAIT: begin
                if (r_timer == '0) begin
                    n_state = ST_EMIT;
                end else begin
                    n_timer = r_timer - 1'b1;
                end
            end
            ST_EMIT: begin
                if (out_acc) begin
                    if ((r_cmd == i2cm_pkg::CMD_WRITE && bit_ph && r_ph[0]) ||
                        (r_cmd == i2cm_pkg::CMD_READ && !r_ph[0])) begin
                        n_shift = {r_shift[i2cm_pkg::DATA_W-2:0],
                                   r_shift[i2cm_pkg::DATA_W-1]};
                    end
                    if (r_out.last_phase) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_WAIT;
                        n_ph    = r_ph + 1'b1;
                        n_timer = r_half;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ph    <= '0;
            r_timer <= '0;
        end else begin
            r_state <= n_state;
            r_ph    <= n_ph;
            r_timer <= n_timer;
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift <= n_shift;
        if (in_acc) begin
            r_cmd  <= i_cmd.cmd;
            r_ackl <= i_cmd.ack_level;
            r_tmo  <= tmo_now;
        end
        if (r_state == ST_WAIT && r_timer == '0) begin
            r_out <= n_out;
        end
    end

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ready |-> !o_res.valid)
        else $error("request taken while a phase is pending");

    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.ready && o_res.last_phase) |=> i_cmd.ready)
        else $error("engine not idle after last phase");

    a_status_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> !(o_res.acked && o_res.timed_out))
        else $error("ack and timeout both set");

    a_released_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.sda_drive) |-> !o_res.sda_level)
        else $error("sda level set while released");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.acked || o_res.timed_out || o_res.read_byte != '0))
            |-> o_res.last_phase)
        else $error("status outside last phase");

endmodule

>>> bench/i2c_master_bit_engine_tb.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_tb
// self-checking bench for the i2c master bit engine
// ----------------------------------------------------------------------------
// Builds the expected line phases of every accepted request in the bench
// and checks each phase on the result channel in order. A table of directed
// requests runs first at the reset timing. Random bus transactions and loose
// requests follow under several timing settings, including a zero half
// period, a zero poll limit and the largest values, with random idling on
// both channels.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_tb;

    typedef i2cm_pkg::t_phase t_phase;

    localparam int MAX_PHASES  = 2 * i2cm_pkg::BITS_PER_BYTE + 8;
    localparam int NUM_ROWS    = 25;
    localparam int CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic [i2cm_pkg::CMD_W-1:0]  cmd;
        logic [i2cm_pkg::DATA_W-1:0] tx_byte;
        logic                        ack_level;
        logic [i2cm_pkg::DATA_W-1:0] bus_read_bits;
        logic [i2cm_pkg::POLL_W-1:0] slave_ack_delay;
    } t_request;

    typedef struct packed {
        t_request rq;
        logic     typed;
        t_phase   last;
    } t_vector;

    localparam t_phase NO_PHASE = '0;

    logic i_clk;
    logic i_rst_n;

    i2cm_cmd_if cmd_if ();
    i2cm_res_if res_if ();
    i2cm_cfg_if cfg_if ();

    i2c_master_bit_engine DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    logic [i2cm_pkg::HALF_W-1:0] half_cycles;
    logic [i2cm_pkg::POLL_W-1:0] poll_limit;

    t_phase  line_seq [0:MAX_PHASES-1];
    int      line_len;
    t_phase  pending_phases [$];
    t_vector rows [0:NUM_ROWS-1];

    int  accepted_cmds;
    int  ignored_cmds;
    int  checked_phases;
    int  timeouts_seen;
    int  mismatches;
    int  cycle_count = 0;
    int  stall_left = 0;
    bit  calm;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("no progress after %0d cycles", cycle_count);
            $display("Verification failed");
            $finish;
        end
    end

    // receiver stalls
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            res_if.ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 14);
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    function void flag_mismatch(input string what, input t_phase want,
                                input t_phase got);
        mismatches++;
        if (mismatches <= 10)
            $display("%s at phase %0d: exp scl=%b drv=%b sda=%b last=%b byte=%h ack=%b tmo=%b,%s",
                     what, checked_phases, want.scl_level, want.sda_drive, want.sda_level,
                     want.last_phase, want.read_byte, want.acked, want.timed_out,
                     $sformatf(" got scl=%b drv=%b sda=%b last=%b byte=%h ack=%b tmo=%b",
                               got.scl_level, got.sda_drive, got.sda_level, got.last_phase,
                               got.read_byte, got.acked, got.timed_out));
    endfunction

    always @(posedge i_clk) begin : check_phase
        t_phase got;
        t_phase want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got.scl_level  = res_if.scl_level;
            got.sda_drive  = res_if.sda_drive;
            got.sda_level  = res_if.sda_level;
            got.last_phase = res_if.last_phase;
            got.read_byte  = res_if.read_byte;
            got.acked      = res_if.acked;
            got.timed_out  = res_if.timed_out;
            if (pending_phases.size() == 0) begin
                flag_mismatch("unexpected phase", NO_PHASE, got);
            end else begin
                want = pending_phases.pop_front();
                if (want !== got)
                    flag_mismatch("wrong phase", want, got);
            end
            checked_phases++;
        end
    end

    function void add_phase(input logic scl, input logic drv, input logic lvl);
        t_phase p;
        p = '0;
        p.scl_level = scl;
        p.sda_drive = drv;
        p.sda_level = drv & lvl;
        line_seq[line_len] = p;
        line_len++;
    endfunction

    function void predict_line(input t_request rq);
        int unsigned limit;
        logic        tmo;
        t_phase      p;
        int          i;
        line_len = 0;
        tmo = 1'b0;
        case (rq.cmd)
            i2cm_pkg::CMD_START: begin
                add_phase(1'b1, 1'b1, 1'b1);
                add_phase(1'b1, 1'b1, 1'b0);
                add_phase(1'b0, 1'b1, 1'b0);
            end
            i2cm_pkg::CMD_STOP: begin
                add_phase(1'b1, 1'b1, 1'b0);
                add_phase(1'b1, 1'b1, 1'b1);
            end
            i2cm_pkg::CMD_ACK: begin
                add_phase(1'b1, 1'b1, rq.ack_level);
                add_phase(1'b0, 1'b1, rq.ack_level);
            end
            i2cm_pkg::CMD_WRITE: begin
                for (i = i2cm_pkg::BITS_PER_BYTE - 1; i >= 0; i--) begin
                    add_phase(1'b1, 1'b1, rq.tx_byte[i]);
                    add_phase(1'b0, 1'b1, rq.tx_byte[i]);
                end
                add_phase(1'b0, 1'b0, 1'b0);
                add_phase(1'b1, 1'b0, 1'b0);
                // a zero limit counts as a full wrap of the poll counter
                limit = (poll_limit == 0) ? 256 : poll_limit;
                tmo = (rq.slave_ack_delay >= limit);
                if (tmo) begin
                    add_phase(1'b1, 1'b1, 1'b0);
                    add_phase(1'b1, 1'b1, 1'b1);
                end else begin
                    add_phase(1'b0, 1'b1, rq.tx_byte[0]);
                end
            end
            i2cm_pkg::CMD_READ: begin
                for (i = 0; i < i2cm_pkg::BITS_PER_BYTE; i++) begin
                    add_phase(1'b1, 1'b0, 1'b0);
                    add_phase(1'b0, 1'b0, 1'b0);
                end
            end
            default: begin
            end
        endcase
        if (line_len > 0) begin
            p = line_seq[line_len - 1];
            p.last_phase = 1'b1;
            if (rq.cmd == i2cm_pkg::CMD_WRITE) begin
                p.acked     = ~tmo;
                p.timed_out = tmo;
            end
            if (rq.cmd == i2cm_pkg::CMD_READ)
                p.read_byte = rq.bus_read_bits;
            line_seq[line_len - 1] = p;
        end
        if (tmo)
            timeouts_seen++;
    endfunction

    task automatic issue(input t_request rq, input logic typed, input t_phase typed_last);
        int gap;
        int k;
        if (!calm && $urandom_range(0, 3) == 0) begin
            cmd_if.valid <= 1'b0;
            gap = $urandom_range(1, 15);
            repeat (gap) @(posedge i_clk);
        end
        cmd_if.valid           <= 1'b1;
        cmd_if.cmd             <= rq.cmd;
        cmd_if.tx_byte         <= rq.tx_byte;
        cmd_if.ack_level       <= rq.ack_level;
        cmd_if.bus_read_bits   <= rq.bus_read_bits;
        cmd_if.slave_ack_delay <= rq.slave_ack_delay;
        do @(posedge i_clk); while (!cmd_if.ready);
        predict_line(rq);
        if (typed && line_len > 0)
            line_seq[line_len - 1] = typed_last;
        for (k = 0; k < line_len; k++)
            pending_phases.push_back(line_seq[k]);
        if (rq.cmd > i2cm_pkg::CMD_ACK)
            ignored_cmds++;
        else
            accepted_cmds++;
    endtask

    // register writes only while the engine is idle
    task automatic set_timing(input logic [i2cm_pkg::HALF_W-1:0] half,
                              input logic [i2cm_pkg::POLL_W-1:0] polls);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= i2cm_pkg::REG_HALF_PERIOD;
        cfg_if.data  <= half;
        do @(posedge i_clk); while (!cfg_if.ready);
        half_cycles = half;
        cfg_if.index <= i2cm_pkg::REG_ACK_POLLS;
        cfg_if.data  <= {{(i2cm_pkg::HALF_W-i2cm_pkg::POLL_W){1'b0}}, polls};
        do @(posedge i_clk); while (!cfg_if.ready);
        poll_limit = polls;
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic settle();
        cmd_if.valid <= 1'b0;
        while (pending_phases.size() != 0) @(posedge i_clk);
        repeat (int'(half_cycles) + 40) @(posedge i_clk);
    endtask

    function automatic t_request req(input logic [i2cm_pkg::CMD_W-1:0] cmd,
                                     input logic [7:0] tx,
                                     input logic ackl, input logic [7:0] rbits,
                                     input logic [7:0] delay);
        t_request rq;
        rq.cmd             = cmd;
        rq.tx_byte         = tx;
        rq.ack_level       = ackl;
        rq.bus_read_bits   = rbits;
        rq.slave_ack_delay = delay;
        return rq;
    endfunction

    function automatic t_phase closing_phase(input logic scl, input logic drv, input logic lvl,
                                             input logic [7:0] rbyte, input logic ack,
                                             input logic tmo);
        t_phase p;
        p.scl_level  = scl;
        p.sda_drive  = drv;
        p.sda_level  = lvl;
        p.last_phase = 1'b1;
        p.read_byte  = rbyte;
        p.acked      = ack;
        p.timed_out  = tmo;
        return p;
    endfunction

    function automatic t_vector mk_row(input t_request rq, input logic typed, input t_phase last);
        t_vector v;
        v.rq    = rq;
        v.typed = typed;
        v.last  = last;
        return v;
    endfunction

    function automatic t_request noisy(input logic [i2cm_pkg::CMD_W-1:0] cmd);
        return req(cmd, 8'($urandom), 1'($urandom), 8'($urandom), 8'($urandom));
    endfunction

    // mostly lands on or next to the poll limit
    function automatic logic [7:0] ack_delay();
        int unsigned limit;
        limit = (poll_limit == 0) ? 256 : poll_limit;
        case ($urandom_range(0, 3))
            0:       return 8'(limit - 1);
            1:       return (limit > 255) ? 8'd255 : 8'(limit);
            2:       return 8'($urandom_range(0, limit - 1));
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic t_request random_request();
        t_request rq;
        int       pick;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            rq = noisy(3'($urandom_range(5, 7)));
        else if (pick < 22)
            rq = noisy(i2cm_pkg::CMD_START);
        else if (pick < 36)
            rq = noisy(i2cm_pkg::CMD_STOP);
        else if (pick < 66)
            rq = noisy(i2cm_pkg::CMD_WRITE);
        else if (pick < 86)
            rq = noisy(i2cm_pkg::CMD_READ);
        else
            rq = noisy(i2cm_pkg::CMD_ACK);
        if (rq.cmd == i2cm_pkg::CMD_WRITE)
            rq.slave_ack_delay = ack_delay();
        return rq;
    endfunction

    task automatic random_transaction();
        t_request   rq;
        logic [7:0] addr;
        int         n;
        int         k;
        addr = 8'($urandom);
        n = $urandom_range(1, 3);
        issue(noisy(i2cm_pkg::CMD_START), 1'b0, NO_PHASE);
        rq = noisy(i2cm_pkg::CMD_WRITE);
        rq.tx_byte = addr;
        rq.slave_ack_delay = ack_delay();
        issue(rq, 1'b0, NO_PHASE);
        for (k = 0; k < n; k++) begin
            if (addr[0]) begin
                issue(noisy(i2cm_pkg::CMD_READ), 1'b0, NO_PHASE);
                rq = noisy(i2cm_pkg::CMD_ACK);
                rq.ack_level = (k == n - 1);
                issue(rq, 1'b0, NO_PHASE);
            end else begin
                rq = noisy(i2cm_pkg::CMD_WRITE);
                rq.slave_ack_delay = ack_delay();
                issue(rq, 1'b0, NO_PHASE);
            end
        end
        issue(noisy(i2cm_pkg::CMD_STOP), 1'b0, NO_PHASE);
    endtask

    task automatic random_stage(input int n);
        int target;
        target = accepted_cmds + n;
        while (accepted_cmds < target) begin
            if ($urandom_range(0, 3) != 0)
                random_transaction();
            else
                issue(random_request(), 1'b0, NO_PHASE);
        end
    endtask

    initial begin : stimulus
        int r;
        i_rst_n                <= 1'b0;
        cmd_if.valid           <= 1'b0;
        cmd_if.cmd             <= i2cm_pkg::CMD_START;
        cmd_if.tx_byte         <= '0;
        cmd_if.ack_level       <= 1'b0;
        cmd_if.bus_read_bits   <= '0;
        cmd_if.slave_ack_delay <= '0;
        cfg_if.valid           <= 1'b0;
        cfg_if.index           <= i2cm_pkg::REG_HALF_PERIOD;
        cfg_if.data            <= '0;
        half_cycles    = i2cm_pkg::HALF_PERIOD_RESET;
        poll_limit     = i2cm_pkg::ACK_POLLS_RESET;
        calm           = 1'b0;
        accepted_cmds  = 0;
        ignored_cmds   = 0;
        checked_phases = 0;
        timeouts_seen  = 0;
        mismatches     = 0;

        rows[0]  = mk_row(req(i2cm_pkg::CMD_START, 8'h00, 1'b0, 8'h00, 8'h00), 1'b1,
                          closing_phase(1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0));
        rows[1]  = mk_row(req(i2cm_pkg::CMD_STOP, 8'hFF, 1'b1, 8'hFF, 8'hFF), 1'b1,
                          closing_phase(1'b1, 1'b1, 1'b1, 8'h00, 1'b0, 1'b0));
        rows[2]  = mk_row(req(i2cm_pkg::CMD_WRITE, 8'hA5, 1'b0, 8'h00, 8'd0), 1'b1,
                          closing_phase(1'b0, 1'b1, 1'b1, 8'h00, 1'b1, 1'b0));
        rows[3]  = mk_row(req(i2cm_pkg::CMD_WRITE, 8'h00, 1'b1, 8'hFF, 8'd19), 1'b1,
                          closing_phase(1'b0, 1'b1, 1'b0, 8'h00, 1'b1, 1'b0));
        rows[4]  = mk_row(req(i2cm_pkg::CMD_WRITE, 8'hFF, 1'b0, 8'h00, 8'd20), 1'b1,
                          closing_phase(1'b1, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1));
        rows[5]  = mk_row(req(i2cm_pkg::CMD_WRITE, 8'h00, 1'b1, 8'hFF, 8'd255), 1'b1,
                          closing_phase(1'b1, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1));
        rows[6]  = mk_row(req(i2cm_pkg::CMD_WRITE, 8'h80, 1'b0, 8'h00, 8'd21), 1'b0,
                          NO_PHASE);
        rows[7]  = mk_row(req(i2cm_pkg::CMD_WRITE, 8'h01, 1'b0, 8'h00, 8'd1), 1'b0,
                          NO_PHASE);
        rows[8]  = mk_row(req(i2cm_pkg::CMD_READ, 8'h00, 1'b0, 8'hFF, 8'h00), 1'b1,
                          closing_phase(1'b0, 1'b0, 1'b0, 8'hFF, 1'b0, 1'b0));
        rows[9]  = mk_row(req(i2cm_pkg::CMD_READ, 8'hFF, 1'b1, 8'h00, 8'hFF), 1'b1,
                          closing_phase(1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0));
        rows[10] = mk_row(req(i2cm_pkg::CMD_READ, 8'h00, 1'b0, 8'h80, 8'h00), 1'b0,
                          NO_PHASE);
        rows[11] = mk_row(req(i2cm_pkg::CMD_READ, 8'h00, 1'b0, 8'h01, 8'h00), 1'b0,
                          NO_PHASE);
        rows[12] = mk_row(req(i2cm_pkg::CMD_ACK, 8'h00, 1'b0, 8'h00, 8'h00), 1'b1,
                          closing_phase(1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0));
        rows[13] = mk_row(req(i2cm_pkg::CMD_ACK, 8'hFF, 1'b1, 8'hFF, 8'hFF), 1'b1,
                          closing_phase(1'b0, 1'b1, 1'b1, 8'h00, 1'b0, 1'b0));
        // unknown codes give no phases
        rows[14] = mk_row(req(3'd5, 8'hFF, 1'b1, 8'hFF, 8'hFF), 1'b0, NO_PHASE);
        rows[15] = mk_row(req(3'd6, 8'h00, 1'b0, 8'h00, 8'h00), 1'b0, NO_PHASE);
        rows[16] = mk_row(req(3'd7, 8'hFF, 1'b1, 8'hFF, 8'hFF), 1'b0, NO_PHASE);
        rows[17] = mk_row(req(i2cm_pkg::CMD_START, 8'h5A, 1'b1, 8'hA5, 8'h33), 1'b0,
                          NO_PHASE);
        rows[18] = mk_row(req(i2cm_pkg::CMD_WRITE, 8'hA0, 1'b0, 8'h00, 8'd3), 1'b0,
                          NO_PHASE);
        rows[19] = mk_row(req(i2cm_pkg::CMD_WRITE, 8'h5A, 1'b1, 8'h00, 8'd0), 1'b0,
                          NO_PHASE);
        rows[20] = mk_row(req(i2cm_pkg::CMD_START, 8'h00, 1'b0, 8'h00, 8'h00), 1'b0,
                          NO_PHASE);
        rows[21] = mk_row(req(i2cm_pkg::CMD_WRITE, 8'hA1, 1'b0, 8'h00, 8'd0), 1'b0,
                          NO_PHASE);
        rows[22] = mk_row(req(i2cm_pkg::CMD_READ, 8'h00, 1'b0, 8'h3C, 8'h00), 1'b0,
                          NO_PHASE);
        rows[23] = mk_row(req(i2cm_pkg::CMD_ACK, 8'h00, 1'b1, 8'h00, 8'h00), 1'b0,
                          NO_PHASE);
        rows[24] = mk_row(req(i2cm_pkg::CMD_STOP, 8'h00, 1'b0, 8'h00, 8'h00), 1'b0,
                          NO_PHASE);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (r = 0; r < NUM_ROWS; r++)
            issue(rows[r].rq, rows[r].typed, rows[r].last);
        settle();

        // zero half period and zero poll limit
        set_timing(16'd0, 8'd0);
        issue(req(i2cm_pkg::CMD_WRITE, 8'hC3, 1'b0, 8'h00, 8'd255), 1'b1,
              closing_phase(1'b0, 1'b1, 1'b1, 8'h00, 1'b1, 1'b0));
        random_stage(40);
        settle();

        set_timing(16'd1, 8'd1);
        random_stage(40);
        settle();

        // longest half period, kept to one short request
        set_timing(16'hFFFF, 8'd255);
        issue(noisy(i2cm_pkg::CMD_STOP), 1'b0, NO_PHASE);
        settle();

        set_timing(16'($urandom_range(2, 40)), 8'd255);
        random_stage(30);
        settle();

        set_timing(16'($urandom_range(2, 60)), 8'($urandom_range(1, 254)));
        random_stage(40);
        settle();

        calm = 1'b1;
        set_timing(i2cm_pkg::HALF_PERIOD_RESET, 8'($urandom_range(1, 255)));
        random_stage(25);
        settle();

        $display("%0d commands run and %0d unknown codes dropped, %0d line phases checked",
                 accepted_cmds, ignored_cmds, checked_phases);
        $display("%0d ack polls timed out; half periods 0 to 65535, poll limits 0 to 255",
                 timeouts_seen);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("Verification failed");
        end
        $finish;
    end

endmodule

>>> sim.f
design/i2cm_pkg.sv
design/i2cm_if.sv
design/i2c_master_bit_engine.sv
bench/i2c_master_bit_engine_tb.sv
